### design/hcww_pkg.sv
package hcww_pkg;

    // Store geometry.
    localparam int MODULE_SLOTS = 4;
    localparam int STORE_WORDS  = 1024;
    localparam int CONFIG_SLOTS = 4;
    localparam int USED_SLOTS   = (MODULE_SLOTS < CONFIG_SLOTS) ? MODULE_SLOTS : CONFIG_SLOTS;
    localparam int STORE_DEPTH  = MODULE_SLOTS * STORE_WORDS;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_W    = $clog2(CONFIG_SLOTS);

    // Field widths.
    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 2;
    localparam int OFFS_W  = 16;
    localparam int NOFFS_W = OFFS_W + 1;
    localparam int CNT_W   = 6;
    localparam int ID_W    = 7;
    localparam int CFG_W   = 8;

    // Header layout.
    localparam int ID_LSB  = 24;
    localparam int OP_LSB  = 22;
    localparam int CNT_LSB = 16;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_OR    = 2'd1,
        OP_AND   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_HEADER       = 3'd0,
        KIND_APPLIED      = 3'd1,
        KIND_NO_MODULE    = 3'd2,
        KIND_OUT_OF_RANGE = 3'd3,
        KIND_READ_HEADER  = 3'd4
    } word_kind_t;

    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic              list_start;
    } in_t;

    typedef struct packed {
        word_kind_t        word_kind;
        logic [SLOT_W-1:0] hit_slot;
        logic [OFFS_W-1:0] word_offset;
        logic [WORD_W-1:0] stored_value;
    } out_t;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_DECODE = 2'd2,
        ST_MODIFY = 2'd3
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic mem_read;
        logic commit_simple;
        logic commit_mem;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic mem_hit;
        logic out_free;
    } ctl_status_t;

endpackage

### design/hcww_ctrl.sv
module hcww_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hcww_pkg::ctl_status_t status,
    output hcww_pkg::ctl_cmd_t    cmd
);

    hcww_pkg::ctl_state_t state_reg;
    hcww_pkg::ctl_state_t state_next;

    // State register; reset starts the store clearing pass.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hcww_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            hcww_pkg::ST_CLEAR: begin
                if (status.clear_done) state_next = hcww_pkg::ST_IDLE;
            end
            hcww_pkg::ST_IDLE: begin
                if (s_valid) state_next = hcww_pkg::ST_DECODE;
            end
            hcww_pkg::ST_DECODE: begin
                if (status.mem_hit) begin
                    state_next = hcww_pkg::ST_MODIFY;
                end else if (status.out_free) begin
                    state_next = hcww_pkg::ST_IDLE;
                end
            end
            hcww_pkg::ST_MODIFY: begin
                if (status.out_free) state_next = hcww_pkg::ST_IDLE;
            end
            default: state_next = hcww_pkg::ST_CLEAR;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            hcww_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
            end
            hcww_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            hcww_pkg::ST_DECODE: begin
                cmd.mem_read      = status.mem_hit;
                cmd.commit_simple = !status.mem_hit && status.out_free;
            end
            hcww_pkg::ST_MODIFY: begin
                cmd.commit_mem = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/hcww_datapath.sv
module hcww_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  hcww_pkg::ctl_cmd_t               cmd,
    output hcww_pkg::ctl_status_t            status,
    input  hcww_pkg::in_t                    s_data,
    input  logic                             cfg_we,
    input  logic [hcww_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hcww_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             m_ready,
    output logic                             m_valid,
    output hcww_pkg::out_t                   m_data
);

    // Configuration and message context.
    logic [hcww_pkg::CFG_W-1:0]   slot_reg [hcww_pkg::CONFIG_SLOTS];
    logic                         in_payload_reg;
    hcww_pkg::op_t                pending_op_reg;
    logic [hcww_pkg::CNT_W-1:0]   words_remaining_reg;
    logic [hcww_pkg::NOFFS_W-1:0] next_offset_reg;
    logic                         target_found_reg;
    logic [hcww_pkg::SLOT_W-1:0]  target_slot_reg;

    hcww_pkg::in_t                item_reg;
    hcww_pkg::out_t               out_reg;
    hcww_pkg::out_t               out_next;
    logic                         out_valid_reg;
    logic [hcww_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic [hcww_pkg::WORD_W-1:0]  store_mem [hcww_pkg::STORE_DEPTH];
    logic [hcww_pkg::WORD_W-1:0]  rdata_reg;

    logic                         is_header;
    logic                         in_range;
    logic [hcww_pkg::ID_W-1:0]    hdr_id;
    hcww_pkg::op_t                hdr_op;
    logic [hcww_pkg::CNT_W-1:0]   hdr_cnt;
    logic                         hdr_found;
    logic [hcww_pkg::SLOT_W-1:0]  hdr_slot;
    logic [hcww_pkg::ADDR_W-1:0]  item_addr;
    logic [hcww_pkg::ADDR_W-1:0]  wr_addr;
    logic [hcww_pkg::WORD_W-1:0]  wr_data;
    logic [hcww_pkg::WORD_W-1:0]  modified;
    logic                         commit;

    // Header fields of the captured word.
    assign hdr_id  = item_reg.message_word[hcww_pkg::ID_LSB +: hcww_pkg::ID_W];
    assign hdr_op  = hcww_pkg::op_t'(item_reg.message_word[hcww_pkg::OP_LSB +: 2]);
    assign hdr_cnt = {1'b0, item_reg.message_word[hcww_pkg::CNT_LSB +: 5]}
                     + hcww_pkg::CNT_W'(1);

    assign is_header = item_reg.list_start || !in_payload_reg;
    assign in_range  = next_offset_reg < hcww_pkg::NOFFS_W'(hcww_pkg::STORE_WORDS);
    assign commit    = cmd.commit_simple || cmd.commit_mem;

    // Lowest resident slot that holds the addressed module.
    always_comb begin
        hdr_found = 1'b0;
        hdr_slot  = '0;
        for (int i = 0; i < hcww_pkg::USED_SLOTS; i++) begin
            if (!hdr_found && slot_reg[i] == {1'b0, hdr_id}) begin
                hdr_found = 1'b1;
                hdr_slot  = hcww_pkg::SLOT_W'(i);
            end
        end
    end

    // Status toward the controller.
    assign status.mem_hit    = !is_header && target_found_reg && in_range;
    assign status.out_free   = !out_valid_reg || m_ready;
    assign status.clear_done = clr_addr_reg == hcww_pkg::ADDR_W'(hcww_pkg::STORE_DEPTH - 1);

    // Store address of the current payload word.
    assign item_addr = hcww_pkg::ADDR_W'(target_slot_reg)
                       * hcww_pkg::ADDR_W'(hcww_pkg::STORE_WORDS)
                       + hcww_pkg::ADDR_W'(next_offset_reg);

    // Read-modify-write operation on the fetched word.
    always_comb begin
        case (pending_op_reg)
            hcww_pkg::OP_WRITE: modified = item_reg.message_word;
            hcww_pkg::OP_OR:    modified = rdata_reg | item_reg.message_word;
            default:            modified = rdata_reg & item_reg.message_word;
        endcase
    end

    assign wr_addr = cmd.clear_step ? clr_addr_reg : item_addr;
    assign wr_data = cmd.clear_step ? '0 : modified;

    // Control store: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.clear_step || cmd.commit_mem) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_read) begin
            rdata_reg <= store_mem[item_addr];
        end
    end

    // Clearing pass address.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_step && !status.clear_done) begin
            clr_addr_reg <= clr_addr_reg + hcww_pkg::ADDR_W'(1);
        end
    end

    // Slot registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < hcww_pkg::CONFIG_SLOTS; i++) begin
                slot_reg[i] <= hcww_pkg::CFG_W'(128);
            end
        end else if (cfg_we) begin
            slot_reg[cfg_index] <= cfg_data;
        end
    end

    // Captured request.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
    end

    // Result of the current request.
    always_comb begin
        out_next = '0;
        if (is_header) begin
            out_next.word_kind   = (hdr_op == hcww_pkg::OP_READ) ?
                                   hcww_pkg::KIND_READ_HEADER : hcww_pkg::KIND_HEADER;
            out_next.hit_slot    = hdr_slot;
            out_next.word_offset = item_reg.message_word[hcww_pkg::OFFS_W-1:0];
        end else begin
            out_next.hit_slot    = target_slot_reg;
            out_next.word_offset = next_offset_reg[hcww_pkg::OFFS_W-1:0];
            if (cmd.commit_mem) begin
                out_next.word_kind    = hcww_pkg::KIND_APPLIED;
                out_next.stored_value = modified;
            end else if (!target_found_reg) begin
                out_next.word_kind = hcww_pkg::KIND_NO_MODULE;
            end else begin
                out_next.word_kind = hcww_pkg::KIND_OUT_OF_RANGE;
            end
        end
    end

    // Context update when a request completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg      <= 1'b0;
            pending_op_reg      <= hcww_pkg::OP_WRITE;
            words_remaining_reg <= '0;
            next_offset_reg     <= '0;
            target_found_reg    <= 1'b0;
            target_slot_reg     <= '0;
        end else if (commit) begin
            if (is_header) begin
                target_found_reg <= hdr_found;
                target_slot_reg  <= hdr_slot;
                next_offset_reg  <= {1'b0, item_reg.message_word[hcww_pkg::OFFS_W-1:0]};
                pending_op_reg   <= hdr_op;
                if (hdr_op == hcww_pkg::OP_READ) begin
                    in_payload_reg      <= 1'b0;
                    words_remaining_reg <= '0;
                end else begin
                    in_payload_reg      <= 1'b1;
                    words_remaining_reg <= hdr_cnt;
                end
            end else begin
                // Offsets saturate at one past the 16-bit range.
                if (!next_offset_reg[hcww_pkg::NOFFS_W-1]) begin
                    next_offset_reg <= next_offset_reg + hcww_pkg::NOFFS_W'(1);
                end
                if (words_remaining_reg <= hcww_pkg::CNT_W'(1)) begin
                    words_remaining_reg <= '0;
                    in_payload_reg      <= 1'b0;
                end else begin
                    words_remaining_reg <= words_remaining_reg - hcww_pkg::CNT_W'(1);
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    // A result is never loaded over one that has not been taken.
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> status.out_free)
        else $error("result loaded while output register is occupied");

    // A store write from a request only targets a resident module in range.
    a_write_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit_mem |-> (!is_header && target_found_reg && in_range))
        else $error("store write without a valid target");

    // The running offset never passes one beyond the 16-bit range.
    a_offset_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        next_offset_reg[hcww_pkg::NOFFS_W-1] |-> (next_offset_reg[hcww_pkg::OFFS_W-1:0] == '0))
        else $error("payload offset passed its saturation value");

    // While payload is expected, at least one word remains.
    a_payload_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_payload_reg |-> (words_remaining_reg != '0))
        else $error("payload expected with no words remaining");
`endif

endmodule

### design/host_command_word_writer.sv
// Parses host message words one request at a time and applies write, OR and
// AND payloads to a control store of four slots by 1024 words. A header, and a
// payload word that is dropped, is captured, decoded and registered once the
// output register is free; a payload word that reaches the store also passes a
// modify state for the read-modify-write through the store's single registered
// read port. A result waits in an output register while the next request is
// taken. After reset a clearing pass zeroes the store, one word a cycle, while
// s_ready stays low; slot registers may be written at any time.
module host_command_word_writer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  hcww_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output hcww_pkg::out_t                 m_data,
    input  logic                           cfg_we,
    input  logic [hcww_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcww_pkg::CFG_W-1:0]     cfg_data
);

    hcww_pkg::ctl_cmd_t    cmd;
    hcww_pkg::ctl_status_t status;

    // Sequencing of each request.
    hcww_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Context, store and result register.
    hcww_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule
